[rtl/rar_pkg.sv]
// Shared types, constants and helpers for the rational arithmetic reducer.
`default_nettype none

package rar_pkg;

	localparam int unsigned DATA_WIDTH = 64;
	localparam int unsigned HALF_W     = DATA_WIDTH / 2;
	localparam int unsigned PROD_W     = 2 * DATA_WIDTH;
	localparam int unsigned CNT_W      = $clog2(DATA_WIDTH);
	localparam int unsigned IN_W       = 4 * DATA_WIDTH;
	localparam int unsigned OUT_W      = 2 * DATA_WIDTH;
	localparam int unsigned MUL_STEPS  = 4;

	typedef logic [DATA_WIDTH-1:0] mag_t;

	// sign and magnitude, magnitude up to 2^(DATA_WIDTH-1)
	typedef struct packed {
		logic neg;
		mag_t mag;
	} sval_t;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_SUB  = 2'd1,
		OP_MUL  = 2'd2,
		OP_NORM = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		MS_P1  = 2'd0,
		MS_P2  = 2'd1,
		MS_NUM = 2'd2,
		MS_DEN = 2'd3
	} msel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_MUL,
		S_MUL_ST,
		S_ADD,
		S_CHECK,
		S_GCD,
		S_DIV,
		S_DIV_END,
		S_FIN
	} state_t;

	typedef struct packed {
		logic       load;
		logic       copy;
		logic       mul_clr;
		logic       mul_pp;
		logic       mul_acc;
		logic [1:0] mul_idx;
		msel_t      mul_sel;
		logic       mul_store;
		logic       add;
		logic       check;
		logic       gcd_step;
		logic       div_init;
		logic       div_step;
		logic       div_end;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic to_gcd;
		logic gcd_done;
		logic out_busy;
	} dp_stat_t;

	function automatic sval_t decode(input mag_t raw);
		sval_t r;
		r.neg = raw[DATA_WIDTH-1];
		r.mag = r.neg ? (~raw + mag_t'(1)) : raw;
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/rar_ctrl.sv]
// Controller state machine sequencing the multiply, add, gcd and divide steps.
`default_nettype none

module rar_ctrl
	import rar_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dp_stat_t stat,
	output cmd_t          cmd
);

	state_t           state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       prod_q;
	logic             last_prod;
	msel_t            sel;

	assign last_prod = (stat.op == OP_MUL) ? (prod_q == 2'd1) : (prod_q == 2'd2);

	always_comb begin
		case (prod_q)
			2'd0:    sel = (stat.op == OP_MUL) ? MS_NUM : MS_P1;
			2'd1:    sel = (stat.op == OP_MUL) ? MS_DEN : MS_P2;
			default: sel = MS_DEN;
		endcase
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:    if (in_valid) state_nx = S_START;
			S_START:   state_nx = (stat.op == OP_NORM) ? S_CHECK : S_MUL;
			S_MUL:     if (cnt_q == CNT_W'(MUL_STEPS)) state_nx = S_MUL_ST;
			S_MUL_ST: begin
				if (last_prod) state_nx = (stat.op == OP_MUL) ? S_CHECK : S_ADD;
				else           state_nx = S_MUL;
			end
			S_ADD:     state_nx = S_CHECK;
			S_CHECK:   state_nx = stat.to_gcd ? S_GCD : S_FIN;
			S_GCD:     if (stat.gcd_done) state_nx = S_DIV;
			S_DIV:     if (cnt_q == CNT_W'(DATA_WIDTH - 1)) state_nx = S_DIV_END;
			S_DIV_END: state_nx = S_FIN;
			S_FIN:     if (!stat.out_busy) state_nx = S_IDLE;
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mul_sel = sel;
		cmd.mul_idx = cnt_q[1:0];
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_START:   cmd.copy = (stat.op == OP_NORM);
			S_MUL: begin
				cmd.mul_clr = (cnt_q == '0);
				cmd.mul_pp  = (cnt_q != CNT_W'(MUL_STEPS));
				cmd.mul_acc = (cnt_q != '0);
			end
			S_MUL_ST:  cmd.mul_store = 1'b1;
			S_ADD:     cmd.add = 1'b1;
			S_CHECK:   cmd.check = 1'b1;
			S_GCD: begin
				cmd.div_init = stat.gcd_done;
				cmd.gcd_step = !stat.gcd_done;
			end
			S_DIV:     cmd.div_step = 1'b1;
			S_DIV_END: cmd.div_end = 1'b1;
			S_FIN:     cmd.out_load = !stat.out_busy;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			prod_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_MUL || state_q == S_DIV) cnt_q <= cnt_q + CNT_W'(1);
			else                                      cnt_q <= '0;
			if (state_q == S_START)       prod_q <= '0;
			else if (state_q == S_MUL_ST) prod_q <= prod_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

[rtl/rar_dp.sv]
// Datapath: operand registers, shared 32x32 multiplier, adder, gcd and dividers.
`default_nettype none

module rar_dp
	import rar_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [IN_W-1:0] in_data,
	input  wire logic [1:0]      in_user,
	input  wire cmd_t            cmd,
	output dp_stat_t             stat,
	output logic [OUT_W-1:0]     out_data,
	output logic [1:0]           out_user,
	output logic                 out_valid,
	input  wire logic            out_ready
);

	sval_t an_q, ad_q, bn_q, bd_q;
	sval_t p1_q, p2_q, num_q, den_q;
	op_t   op_q;
	logic  ovf_q;

	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] pp_ext;
	logic [DATA_WIDTH-1:0] pp_q;
	logic [1:0]        ppi_q;
	sval_t             mx, my;
	logic [HALF_W-1:0] xh, yh;
	logic              m_neg, m_ovf;

	sval_t             ay;
	logic [DATA_WIDTH:0] asum;
	mag_t              adiff;
	sval_t             ares;
	logic              a_ovf;

	logic              ck_err, ck_zero, nneg;
	stat_t             ck_st;

	mag_t              u_q, v_q, g;
	logic [CNT_W-1:0]  k_q;
	logic              nneg_q;

	mag_t              dv_q, q1_q, q2_q, r1_q, r2_q;
	mag_t              q1_nx, q2_nx, r1_nx, r2_nx;

	logic [DATA_WIDTH-1:0] fnum_q, onum_q;
	logic [DATA_WIDTH-2:0] fden_q, oden_q;
	stat_t                 fst_q, ost_q;
	logic                  ovld_q;

	// one restoring divide step; remainder stays below the divisor
	function automatic logic [2*DATA_WIDTH-1:0] div_lane(input mag_t rem, input mag_t q,
			input mag_t d);
		logic [DATA_WIDTH:0] t;
		logic                b;
		t = {rem, q[DATA_WIDTH-1]};
		b = (t >= {1'b0, d});
		if (b) t = t - {1'b0, d};
		return {t[DATA_WIDTH-1:0], q[DATA_WIDTH-2:0], b};
	endfunction

	// multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			MS_P1:   begin mx = an_q; my = bd_q; end
			MS_P2:   begin mx = bn_q; my = ad_q; end
			MS_NUM:  begin mx = an_q; my = bn_q; end
			default: begin mx = ad_q; my = bd_q; end
		endcase
		xh = cmd.mul_idx[0] ? mx.mag[DATA_WIDTH-1:HALF_W] : mx.mag[HALF_W-1:0];
		yh = cmd.mul_idx[1] ? my.mag[DATA_WIDTH-1:HALF_W] : my.mag[HALF_W-1:0];
		case (ppi_q)
			2'd0:    pp_ext = PROD_W'(pp_q);
			2'd3:    pp_ext = PROD_W'(pp_q) << (2 * HALF_W);
			default: pp_ext = PROD_W'(pp_q) << HALF_W;
		endcase
		m_neg = mx.neg ^ my.neg;
		m_ovf = (|acc_q[PROD_W-1:DATA_WIDTH]) ||
			(acc_q[DATA_WIDTH-1] && (!m_neg || (|acc_q[DATA_WIDTH-2:0])));
	end

	// sign-magnitude add or subtract of the two cross products
	always_comb begin
		ay = p2_q;
		if (op_q == OP_SUB) ay.neg = !p2_q.neg && (|p2_q.mag);
		asum  = {1'b0, p1_q.mag} + {1'b0, ay.mag};
		adiff = (p1_q.mag >= ay.mag) ? (p1_q.mag - ay.mag) : (ay.mag - p1_q.mag);
		if (p1_q.neg == ay.neg) begin
			ares.mag = asum[DATA_WIDTH-1:0];
			ares.neg = p1_q.neg && (|asum);
			a_ovf    = asum[DATA_WIDTH] || (asum[DATA_WIDTH-1] &&
				(!p1_q.neg || (|asum[DATA_WIDTH-2:0])));
		end else begin
			ares.mag = adiff;
			ares.neg = ((p1_q.mag >= ay.mag) ? p1_q.neg : ay.neg) && (|adiff);
			a_ovf    = adiff[DATA_WIDTH-1] && !ares.neg;
		end
	end

	// sign fix-up and error screening ahead of the gcd
	always_comb begin
		nneg   = den_q.neg ? !num_q.neg : num_q.neg;
		ck_st  = ST_OK;
		ck_err = 1'b1;
		if (ovf_q) begin
			ck_st = ST_OVF;
		end else if (den_q.mag == '0) begin
			ck_st = ST_DIV0;
		end else if (den_q.neg && ((num_q.neg && num_q.mag[DATA_WIDTH-1]) ||
				den_q.mag[DATA_WIDTH-1])) begin
			ck_st = ST_OVF;
		end else begin
			ck_err = 1'b0;
		end
		ck_zero = !ck_err && (num_q.mag == '0);
	end

	assign g = (u_q | v_q) << k_q;
	assign {r1_nx, q1_nx} = div_lane(r1_q, q1_q, dv_q);
	assign {r2_nx, q2_nx} = div_lane(r2_q, q2_q, dv_q);

	always_comb begin
		stat.op       = op_q;
		stat.to_gcd   = !ck_err && !ck_zero;
		stat.gcd_done = (u_q == '0) || (v_q == '0);
		stat.out_busy = ovld_q && !out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(in_user);
			an_q  <= decode(in_data[DATA_WIDTH-1:0]);
			ad_q  <= decode(in_data[2*DATA_WIDTH-1:DATA_WIDTH]);
			bn_q  <= decode(in_data[3*DATA_WIDTH-1:2*DATA_WIDTH]);
			bd_q  <= decode(in_data[4*DATA_WIDTH-1:3*DATA_WIDTH]);
			ovf_q <= 1'b0;
		end else if (cmd.mul_store) begin
			ovf_q <= ovf_q | m_ovf;
		end else if (cmd.add) begin
			ovf_q <= ovf_q | a_ovf;
		end

		if (cmd.copy) begin
			num_q <= an_q;
			den_q <= ad_q;
		end else if (cmd.add) begin
			num_q <= ares;
		end else if (cmd.mul_store) begin
			case (cmd.mul_sel)
				MS_P1:   p1_q  <= '{neg: m_neg && (|acc_q[DATA_WIDTH-1:0]),
					mag: acc_q[DATA_WIDTH-1:0]};
				MS_P2:   p2_q  <= '{neg: m_neg && (|acc_q[DATA_WIDTH-1:0]),
					mag: acc_q[DATA_WIDTH-1:0]};
				MS_NUM:  num_q <= '{neg: m_neg && (|acc_q[DATA_WIDTH-1:0]),
					mag: acc_q[DATA_WIDTH-1:0]};
				default: den_q <= '{neg: m_neg && (|acc_q[DATA_WIDTH-1:0]),
					mag: acc_q[DATA_WIDTH-1:0]};
			endcase
		end

		if (cmd.mul_pp) begin
			pp_q  <= xh * yh;
			ppi_q <= cmd.mul_idx;
		end
		if (cmd.mul_clr)      acc_q <= '0;
		else if (cmd.mul_acc) acc_q <= acc_q + pp_ext;

		if (cmd.check) begin
			u_q    <= num_q.mag;
			v_q    <= den_q.mag;
			k_q    <= '0;
			nneg_q <= nneg;
			if (ck_err) begin
				fst_q  <= ck_st;
				fnum_q <= '0;
				fden_q <= '0;
			end else if (ck_zero) begin
				fst_q  <= ST_OK;
				fnum_q <= '0;
				fden_q <= (DATA_WIDTH-1)'(1);
			end
		end else if (cmd.gcd_step) begin
			// binary gcd: strip shared twos, halve a lone even value, subtract odd from odd
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + CNT_W'(1);
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= (u_q - v_q) >> 1;
			end else begin
				v_q <= (v_q - u_q) >> 1;
			end
		end

		if (cmd.div_init) begin
			dv_q <= g;
			q1_q <= num_q.mag;
			q2_q <= den_q.mag;
			r1_q <= '0;
			r2_q <= '0;
		end else if (cmd.div_step) begin
			q1_q <= q1_nx;
			q2_q <= q2_nx;
			r1_q <= r1_nx;
			r2_q <= r2_nx;
		end

		if (cmd.div_end) begin
			fst_q  <= ST_OK;
			fnum_q <= nneg_q ? (~q1_q + mag_t'(1)) : q1_q;
			fden_q <= q2_q[DATA_WIDTH-2:0];
		end

		if (cmd.out_load) begin
			onum_q <= fnum_q;
			oden_q <= fden_q;
			ost_q  <= fst_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovld_q <= 1'b1;
		end else if (out_ready) begin
			ovld_q <= 1'b0;
		end
	end

	assign out_data  = {1'b0, oden_q, onum_q};
	assign out_user  = ost_q;
	assign out_valid = ovld_q;

endmodule

`default_nettype wire

[rtl/rational_arith_reduce_top.sv]
// Sequence from accepting a request to result valid: a normalise with no reduction goes
// straight to the check and the output; a multiply forms two products and an add or subtract
// three, each from four partial products; a reduction then runs binary gcd and 64 divide steps.
// Throughput: one request at a time; the gcd loop and the bit-serial dividers set it.
// A finished result waits in the output register while the next request is taken.
// Reset: arst_n clears the controller and the output valid; nothing else is reset.
`default_nettype none

module rational_arith_reduce_top
	import rar_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // a_num, a_den, b_num, b_den
	input  wire logic [1:0]       s_tuser,  // req_type
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata,  // res_num, res_den, zero pad
	output logic [1:0]            m_tuser   // status
);

	cmd_t     cmd;
	dp_stat_t stat;

	rar_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rar_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

endmodule

`default_nettype wire
